// ===== rtl/core/fihc_pkg.sv =====
// ----------------------------------------------------------------------------
// fihc_pkg
// Types, codes and constants of the firmware image header checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fihc_pkg;

    localparam logic [31:0] PREFIX_WORD  = 32'h6042_0010;
    localparam logic [31:0] MAGIC_A      = 32'h59a0_e842;
    localparam logic [31:0] MAGIC_B      = 32'h4736_3134;
    localparam logic [15:0] KIND_RUNTIME = 16'h8dc9;
    localparam logic [15:0] KIND_BOOT    = 16'hea43;
    localparam logic [15:0] KIND_ROOT    = 16'hb162;
    localparam logic [15:0] TYPE_LOW     = 16'h0100;

    localparam int          POS_W        = 33;
    localparam logic [32:0] POS_MAX      = 33'h1_ffff_ffff;
    localparam logic [32:0] HEADER_BYTES = 33'd24;
    localparam logic [32:0] PREFIX_BYTES = 33'd4;

    // result status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_MAGIC     = 4'd1;
    localparam logic [3:0] ST_HDR_SUM   = 4'd2;
    localparam logic [3:0] ST_RESERVED  = 4'd3;
    localparam logic [3:0] ST_TYPE_LOW  = 4'd4;
    localparam logic [3:0] ST_KIND      = 4'd5;
    localparam logic [3:0] ST_TRUNCATED = 4'd6;
    localparam logic [3:0] ST_BODY_SUM  = 4'd7;
    localparam logic [3:0] ST_EXTRA     = 4'd8;
    localparam logic [3:0] ST_NONE      = 4'd0;

    // image kinds
    localparam logic [1:0] KD_RUNTIME = 2'd0;
    localparam logic [1:0] KD_BOOT    = 2'd1;
    localparam logic [1:0] KD_ROOT    = 2'd2;
    localparam logic [1:0] KD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_image;
    } in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  image_kind;
        logic [31:0] body_length;
        logic [31:0] build_date;
        logic [31:0] build_time;
    } out_t;

    function automatic logic [1:0] kind_of(input logic [15:0] type_high);
        logic [1:0] k;
        begin
            if (type_high == KIND_RUNTIME)
                k = KD_RUNTIME;
            else if (type_high == KIND_BOOT)
                k = KD_BOOT;
            else if (type_high == KIND_ROOT)
                k = KD_ROOT;
            else
                k = KD_UNKNOWN;
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/firmware_image_header_checker_top.sv =====
// ----------------------------------------------------------------------------
// firmware_image_header_checker_top
// Byte-stream checker for a firmware image header and body checksum.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | fihc_pkg::in_t  (byte, last flag)
// out     | output    | out_valid / out_ready| fihc_pkg::out_t (verdict, header)
//
// One byte is taken every cycle while no verdict waits to be taken; the state update is a counter step and an XOR.
// The verdict of an image appears in the result register the cycle after its
// last byte is taken. Input stalls only while a verdict waits to be taken.
// Reset clears all image state; after each verdict the state clears again.
// ----------------------------------------------------------------------------
`default_nettype none

module firmware_image_header_checker_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fihc_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output fihc_pkg::out_t      out_data
);

    logic [32:0]     pos_reg, pos_next;
    logic            prefix_reg, prefix_next;
    logic [31:0]     hw_reg [5];
    logic [31:0]     hw_next [5];
    logic [15:0]     rsv_reg, rsv_next;
    logic [7:0]      body_sum_reg, body_sum_next;
    logic [7:0]      xor_hdr_reg, xor_hdr_next;
    logic [7:0]      xor_body_reg, xor_body_next;
    logic [3:0]      err_reg, err_next;
    logic            out_valid_reg, out_valid_next;
    fihc_pkg::out_t  out_reg, out_next;

    logic            accept;
    logic [7:0]      b;
    logic [32:0]     hi;
    logic [32:0]     body_off;
    logic [4:0]      hi_idx;
    logic            in_hdr;
    logic [31:0]     word0;
    logic [32:0]     rcv;
    logic [32:0]     body_rx;
    logic [32:0]     size_ext;
    logic [3:0]      status;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign b        = in_data.data_byte;
    assign hi       = prefix_reg ? (pos_reg - fihc_pkg::PREFIX_BYTES) : pos_reg;
    assign in_hdr   = (hi < fihc_pkg::HEADER_BYTES);
    assign hi_idx   = hi[4:0];
    assign body_off = hi - fihc_pkg::HEADER_BYTES;
    assign word0    = {hw_reg[0][31:8], b};

    always_comb
    begin
        pos_next      = pos_reg;
        prefix_next   = prefix_reg;
        for (int i = 0; i < 5; i++)
            hw_next[i] = hw_reg[i];
        rsv_next      = rsv_reg;
        body_sum_next = body_sum_reg;
        xor_hdr_next  = xor_hdr_reg;
        xor_body_next = xor_body_reg;
        err_next      = err_reg;
        out_next      = out_reg;
        rcv           = '0;
        body_rx       = '0;
        size_ext      = '0;
        status        = fihc_pkg::ST_OK;

        if (out_valid_reg && !out_ready)
            out_valid_next = 1'b1;
        else
            out_valid_next = 1'b0;

        if (accept)
        begin
            if (in_hdr)
            begin
                if (hi_idx < 5'd20)
                begin
                    case (hi_idx[1:0])
                        2'd0:    hw_next[hi_idx[4:2]][31:24] = b;
                        2'd1:    hw_next[hi_idx[4:2]][23:16] = b;
                        2'd2:    hw_next[hi_idx[4:2]][15:8]  = b;
                        default: hw_next[hi_idx[4:2]][7:0]   = b;
                    endcase
                    xor_hdr_next = xor_hdr_reg ^ b;
                end
                else if (hi_idx == 5'd20)
                begin
                    rsv_next[15:8] = b;
                    xor_hdr_next   = xor_hdr_reg ^ b;
                end
                else if (hi_idx == 5'd21)
                begin
                    rsv_next[7:0] = b;
                    xor_hdr_next  = xor_hdr_reg ^ b;
                end
                else if (hi_idx == 5'd22)
                begin
                    body_sum_next = b;
                    xor_hdr_next  = xor_hdr_reg ^ b;
                end
                else if (err_reg == fihc_pkg::ST_NONE)
                begin
                    // last header byte: header checksum, reserved field, type and kind checks
                    if (xor_hdr_reg != b)
                        err_next = fihc_pkg::ST_HDR_SUM;
                    else if (rsv_reg != 16'd0)
                        err_next = fihc_pkg::ST_RESERVED;
                    else if (hw_reg[1][15:0] != fihc_pkg::TYPE_LOW)
                        err_next = fihc_pkg::ST_TYPE_LOW;
                    else if (fihc_pkg::kind_of(hw_reg[1][31:16]) == fihc_pkg::KD_UNKNOWN)
                        err_next = fihc_pkg::ST_KIND;
                end

                // fourth byte of the first word: prefix or magic
                if (hi_idx == 5'd3)
                begin
                    if (!prefix_reg && word0 == fihc_pkg::PREFIX_WORD)
                    begin
                        prefix_next  = 1'b1;
                        hw_next[0]   = '0;
                        xor_hdr_next = '0;
                    end
                    else if (word0 != fihc_pkg::MAGIC_A && word0 != fihc_pkg::MAGIC_B)
                    begin
                        if (err_reg == fihc_pkg::ST_NONE)
                            err_next = fihc_pkg::ST_MAGIC;
                    end
                end
            end
            else if (body_off < {1'b0, hw_reg[4]})
            begin
                xor_body_next = xor_body_reg ^ b;
            end

            if (pos_reg != fihc_pkg::POS_MAX)
                pos_next = pos_reg + 33'd1;

            if (in_data.end_of_image)
            begin
                rcv      = prefix_next ? (pos_next - fihc_pkg::PREFIX_BYTES) : pos_next;
                body_rx  = rcv - fihc_pkg::HEADER_BYTES;
                size_ext = {1'b0, hw_next[4]};

                if (err_next != fihc_pkg::ST_NONE)
                    status = err_next;
                else if (rcv < fihc_pkg::HEADER_BYTES || body_rx < size_ext)
                    status = fihc_pkg::ST_TRUNCATED;
                else if (xor_body_next != body_sum_next)
                    status = fihc_pkg::ST_BODY_SUM;
                else if (body_rx > size_ext)
                    status = fihc_pkg::ST_EXTRA;
                else
                    status = fihc_pkg::ST_OK;

                out_valid_next       = 1'b1;
                out_next.status      = status;
                out_next.image_kind  = fihc_pkg::kind_of(hw_next[1][31:16]);
                out_next.body_length = hw_next[4];
                out_next.build_date  = hw_next[2];
                out_next.build_time  = hw_next[3];

                // back to the empty state for the next image
                pos_next      = '0;
                prefix_next   = 1'b0;
                for (int i = 0; i < 5; i++)
                    hw_next[i] = '0;
                rsv_next      = '0;
                body_sum_next = '0;
                xor_hdr_next  = '0;
                xor_body_next = '0;
                err_next      = fihc_pkg::ST_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prefix_reg    <= 1'b0;
            for (int i = 0; i < 5; i++)
                hw_reg[i] <= '0;
            rsv_reg       <= '0;
            body_sum_reg  <= '0;
            xor_hdr_reg   <= '0;
            xor_body_reg  <= '0;
            err_reg       <= fihc_pkg::ST_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            prefix_reg    <= prefix_next;
            for (int i = 0; i < 5; i++)
                hw_reg[i] <= hw_next[i];
            rsv_reg       <= rsv_next;
            body_sum_reg  <= body_sum_next;
            xor_hdr_reg   <= xor_hdr_next;
            xor_body_reg  <= xor_body_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/fihc_checker.sv =====
// ----------------------------------------------------------------------------
// fihc_checker
// Port-level assertions for the firmware image header checker.
// ----------------------------------------------------------------------------
`default_nettype none

module fihc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire fihc_pkg::in_t  in_data,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire fihc_pkg::out_t out_data
);

    // a waiting verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("verdict changed while stalled");

    // last byte of an image gives a verdict in the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.end_of_image |=> out_valid)
        else $error("no verdict after last byte");

    // any other byte gives none once the output is free
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.end_of_image && (!out_valid || out_ready)
        |=> !out_valid)
        else $error("verdict without last byte");

    // a clean image always has a known kind
    a_ok_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fihc_pkg::ST_OK
        |-> out_data.image_kind != fihc_pkg::KD_UNKNOWN)
        else $error("status ok with unknown kind");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= fihc_pkg::ST_EXTRA)
        else $error("status code out of range");

endmodule

bind firmware_image_header_checker_top fihc_checker u_fihc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb_firmware_image_header_checker_top.sv =====
// ----------------------------------------------------------------------------
// tb_firmware_image_header_checker_top
// Self-checking bench for the firmware image header checker.
// Images are built as byte streams (clean, with header faults, cut short,
// with bad bodies or trailing bytes, or plain noise) and pushed one byte per
// transaction. A byte-level model of the checker predicts each verdict, which
// is compared field by field with what the block returns. Random sender gaps,
// receiver stalls and one long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_firmware_image_header_checker_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        bit          with_prefix;
        logic [31:0] magic;
        logic [31:0] type_word;
        logic [31:0] date_word;
        logic [31:0] time_word;
        logic [31:0] size_word;
        logic [15:0] reserved;
        logic [7:0]  body_sum_flip;
        logic [7:0]  hdr_sum_flip;
        int          body_bytes;
        int          cut_len;   // 0 keeps the whole image
        int          flip_at;   // -1 leaves every byte intact
        logic [7:0]  flip_mask;
    } image_spec_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    fihc_pkg::in_t   in_data = '0;
    logic            in_ready;
    logic            out_valid;
    logic            out_ready = 1'b0;
    fihc_pkg::out_t  out_data;

    int          cycle_count = 0;
    int          error_count = 0;
    int unsigned bytes_sent = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    logic        hold_armed = 1'b0;
    int          hold_count = 0;

    fihc_pkg::out_t verdict_q[$];

    // model state of the image in flight
    logic [32:0] pos_count;
    bit          prefix_found;
    logic [31:0] hdr_word [5];
    logic [15:0] rsvd_field;
    logic [7:0]  body_sum_byte;
    logic [7:0]  hdr_sum_byte;
    logic [7:0]  hdr_xor;
    logic [7:0]  body_xor;
    logic [3:0]  first_fault;

    firmware_image_header_checker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Verdict model
    // ------------------------------------------------------------------------
    function automatic logic [1:0] classify_kind(input logic [15:0] high_half);
        case (high_half)
            fihc_pkg::KIND_RUNTIME: return fihc_pkg::KD_RUNTIME;
            fihc_pkg::KIND_BOOT:    return fihc_pkg::KD_BOOT;
            fihc_pkg::KIND_ROOT:    return fihc_pkg::KD_ROOT;
            default:                return fihc_pkg::KD_UNKNOWN;
        endcase
    endfunction

    function automatic bit magic_ok(input logic [31:0] w);
        return (w == fihc_pkg::MAGIC_A) || (w == fihc_pkg::MAGIC_B);
    endfunction

    task automatic clear_image_state();
        int i;
        pos_count = '0;
        prefix_found = 1'b0;
        for (i = 0; i < 5; i++)
            hdr_word[i] = '0;
        rsvd_field = '0;
        body_sum_byte = '0;
        hdr_sum_byte = '0;
        hdr_xor = '0;
        body_xor = '0;
        first_fault = fihc_pkg::ST_NONE;
    endtask

    task automatic note_fault(input logic [3:0] code);
        if (first_fault == fihc_pkg::ST_NONE)
            first_fault = code;
    endtask

    task automatic absorb_image_byte(input fihc_pkg::in_t item, output bit done,
                                     output fihc_pkg::out_t verdict);
        logic [32:0] hdr_idx;
        logic [32:0] got;
        logic [7:0]  b;
        int          sh;
        int          w;
        b = item.data_byte;
        done = 1'b0;
        verdict = '0;
        hdr_idx = prefix_found ? pos_count - fihc_pkg::PREFIX_BYTES : pos_count;

        if (hdr_idx < fihc_pkg::HEADER_BYTES)
        begin
            if (hdr_idx < 33'd20)
            begin
                w = int'(hdr_idx[4:2]);
                sh = 8 * (3 - int'(hdr_idx[1:0]));
                hdr_word[w] = hdr_word[w] | (32'(b) << sh);
                hdr_xor ^= b;
            end
            else if (hdr_idx < 33'd22)
            begin
                sh = 8 * (21 - int'(hdr_idx[4:0]));
                rsvd_field = rsvd_field | (16'(b) << sh);
                hdr_xor ^= b;
            end
            else if (hdr_idx == 33'd22)
            begin
                body_sum_byte = b;
                hdr_xor ^= b;
            end
            else
            begin
                hdr_sum_byte = b;
                if (hdr_xor != hdr_sum_byte)
                    note_fault(fihc_pkg::ST_HDR_SUM);
                else if (rsvd_field != 16'h0)
                    note_fault(fihc_pkg::ST_RESERVED);
                else if (hdr_word[1][15:0] != fihc_pkg::TYPE_LOW)
                    note_fault(fihc_pkg::ST_TYPE_LOW);
                else if (classify_kind(hdr_word[1][31:16]) == fihc_pkg::KD_UNKNOWN)
                    note_fault(fihc_pkg::ST_KIND);
            end

            // the first word is either the prefix or the magic
            if (!prefix_found && pos_count == 33'd3)
            begin
                if (hdr_word[0] == fihc_pkg::PREFIX_WORD)
                begin
                    prefix_found = 1'b1;
                    hdr_word[0] = '0;
                    hdr_xor = '0;
                end
                else if (!magic_ok(hdr_word[0]))
                    note_fault(fihc_pkg::ST_MAGIC);
            end
            else if (prefix_found && hdr_idx == 33'd3)
            begin
                if (!magic_ok(hdr_word[0]))
                    note_fault(fihc_pkg::ST_MAGIC);
            end
        end
        else if (hdr_idx - fihc_pkg::HEADER_BYTES < {1'b0, hdr_word[4]})
            body_xor ^= b;

        if (pos_count != fihc_pkg::POS_MAX)
            pos_count = pos_count + 33'd1;

        if (item.end_of_image)
        begin
            got = prefix_found ? pos_count - fihc_pkg::PREFIX_BYTES : pos_count;
            if (first_fault != fihc_pkg::ST_NONE)
                verdict.status = first_fault;
            else if (got < fihc_pkg::HEADER_BYTES ||
                     got - fihc_pkg::HEADER_BYTES < {1'b0, hdr_word[4]})
                verdict.status = fihc_pkg::ST_TRUNCATED;
            else if (body_xor != body_sum_byte)
                verdict.status = fihc_pkg::ST_BODY_SUM;
            else if (got - fihc_pkg::HEADER_BYTES > {1'b0, hdr_word[4]})
                verdict.status = fihc_pkg::ST_EXTRA;
            else
                verdict.status = fihc_pkg::ST_OK;
            verdict.image_kind = classify_kind(hdr_word[1][31:16]);
            verdict.body_length = hdr_word[4];
            verdict.build_date = hdr_word[2];
            verdict.build_time = hdr_word[3];
            done = 1'b1;
            clear_image_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_byte(input fihc_pkg::in_t item);
        bit             has_verdict;
        fihc_pkg::out_t verdict;
        if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(1, 100) <= sender_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_image_byte(item, has_verdict, verdict);
        if (has_verdict)
            verdict_q.push_back(verdict);
        bytes_sent++;
    endtask

    task automatic send_image(input logic [7:0] img[$]);
        fihc_pkg::in_t item;
        int            i;
        for (i = 0; i < img.size(); i++)
        begin
            item.data_byte = img[i];
            item.end_of_image = (i == img.size() - 1);
            send_byte(item);
        end
    endtask

    task automatic send_noise(input int len);
        logic [7:0] img[$];
        int         i;
        for (i = 0; i < len; i++)
            img.push_back(8'($urandom));
        send_image(img);
    endtask

    function automatic image_spec_t sound_spec(input int size);
        image_spec_t s;
        logic [15:0] kind_half;
        case ($urandom_range(0, 2))
            0:       kind_half = fihc_pkg::KIND_RUNTIME;
            1:       kind_half = fihc_pkg::KIND_BOOT;
            default: kind_half = fihc_pkg::KIND_ROOT;
        endcase
        s.with_prefix = 1'($urandom_range(0, 1));
        s.magic = $urandom_range(0, 1) ? fihc_pkg::MAGIC_A : fihc_pkg::MAGIC_B;
        s.type_word = {kind_half, fihc_pkg::TYPE_LOW};
        s.date_word = $urandom;
        s.time_word = $urandom;
        s.size_word = 32'(size);
        s.reserved = '0;
        s.body_sum_flip = '0;
        s.hdr_sum_flip = '0;
        s.body_bytes = size;
        s.cut_len = 0;
        s.flip_at = -1;
        s.flip_mask = '0;
        return s;
    endfunction

    task automatic send_spec(input image_spec_t s);
        logic [7:0]  img[$];
        logic [7:0]  body[$];
        logic [31:0] words [5];
        logic [7:0]  hx;
        logic [7:0]  bx;
        logic [7:0]  v;
        int          i;
        int          k;
        words[0] = s.magic;
        words[1] = s.type_word;
        words[2] = s.date_word;
        words[3] = s.time_word;
        words[4] = s.size_word;
        if (s.with_prefix)
            for (k = 3; k >= 0; k--)
                img.push_back(8'(fihc_pkg::PREFIX_WORD >> (8 * k)));
        hx = '0;
        for (i = 0; i < 5; i++)
            for (k = 3; k >= 0; k--)
            begin
                v = words[i][8*k +: 8];
                img.push_back(v);
                hx ^= v;
            end
        img.push_back(s.reserved[15:8]);
        img.push_back(s.reserved[7:0]);
        hx ^= s.reserved[15:8] ^ s.reserved[7:0];
        bx = '0;
        for (i = 0; i < s.body_bytes; i++)
        begin
            v = 8'($urandom);
            body.push_back(v);
            if (longint'(i) < longint'(s.size_word))
                bx ^= v;
        end
        bx ^= s.body_sum_flip;
        img.push_back(bx);
        hx ^= bx;
        img.push_back(hx ^ s.hdr_sum_flip);
        foreach (body[i])
            img.push_back(body[i]);
        if (s.cut_len > 0)
            while (img.size() > s.cut_len)
                void'(img.pop_back());
        if (s.flip_at >= 0 && s.flip_at < img.size())
            img[s.flip_at] ^= s.flip_mask;
        send_image(img);
    endtask

    // lower valid in the step of the last acceptance, then wait for every verdict
    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_armed && hold_count < HOLD_CYCLES)
        begin
            out_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            out_ready <= ($urandom_range(1, 100) > receiver_stall_pct);
    end

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] seen);
        if (want !== seen)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, seen);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        fihc_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict with none outstanding: status %0d", out_data.status);
                error_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                report_field("status", 32'(want.status), 32'(out_data.status));
                report_field("image_kind", 32'(want.image_kind), 32'(out_data.image_kind));
                report_field("body_length", want.body_length, out_data.body_length);
                report_field("build_date", want.build_date, out_data.build_date);
                report_field("build_time", want.build_time, out_data.build_time);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_clean_images();
        image_spec_t s;
        s = sound_spec(0);
        s.with_prefix = 1'b0;
        s.magic = fihc_pkg::MAGIC_A;
        s.type_word = {fihc_pkg::KIND_RUNTIME, fihc_pkg::TYPE_LOW};
        send_spec(s);
        s = sound_spec(3);
        s.with_prefix = 1'b1;
        s.magic = fihc_pkg::MAGIC_B;
        s.type_word = {fihc_pkg::KIND_BOOT, fihc_pkg::TYPE_LOW};
        send_spec(s);
        s = sound_spec(1);
        s.type_word = {fihc_pkg::KIND_ROOT, fihc_pkg::TYPE_LOW};
        send_spec(s);
        wait_for_verdicts();
    endtask

    task automatic test_header_faults();
        image_spec_t s;
        s = sound_spec(2);
        s.magic = 32'h0000_0000;
        send_spec(s);
        s = sound_spec(2);
        s.hdr_sum_flip = 8'($urandom_range(1, 255));
        send_spec(s);
        s = sound_spec(2);
        s.reserved = 16'($urandom_range(1, 65535));
        send_spec(s);
        s = sound_spec(2);
        s.type_word[15:0] = fihc_pkg::TYPE_LOW ^ 16'($urandom_range(1, 65535));
        send_spec(s);
        s = sound_spec(2);
        s.type_word[31:16] = 16'hffff;
        send_spec(s);
        // several faults at once: the earliest in check order must win
        s = sound_spec(1);
        s.magic = fihc_pkg::MAGIC_A ^ 32'h8000_0000;
        s.reserved = 16'h0001;
        send_spec(s);
        s = sound_spec(1);
        s.hdr_sum_flip = 8'h80;
        s.reserved = 16'h8000;
        send_spec(s);
        // prefix followed by a second prefix word in the magic slot
        s = sound_spec(1);
        s.with_prefix = 1'b1;
        s.magic = fihc_pkg::PREFIX_WORD;
        send_spec(s);
        // one bit away from the prefix, so it is taken as a bad magic
        s = sound_spec(1);
        s.with_prefix = 1'b0;
        s.magic = fihc_pkg::PREFIX_WORD ^ 32'h1;
        send_spec(s);
        wait_for_verdicts();
    endtask

    task automatic test_short_images();
        image_spec_t s;
        send_noise(1);
        s = sound_spec(5);
        s.with_prefix = 1'b1;
        s.cut_len = 4;
        send_spec(s);
        s = sound_spec(5);
        s.with_prefix = 1'b1;
        s.cut_len = 3;
        send_spec(s);
        s = sound_spec(5);
        s.with_prefix = 1'b0;
        s.cut_len = 10;
        send_spec(s);
        s = sound_spec(6);
        s.body_bytes = 3;
        send_spec(s);
        wait_for_verdicts();
    endtask

    task automatic test_body_faults();
        image_spec_t s;
        s = sound_spec(5);
        s.body_sum_flip = 8'($urandom_range(1, 255));
        send_spec(s);
        s = sound_spec(0);
        s.body_bytes = 3;
        send_spec(s);
        // wrong sum and trailing bytes: the sum is reported
        s = sound_spec(2);
        s.body_bytes = 4;
        s.body_sum_flip = 8'h01;
        send_spec(s);
        wait_for_verdicts();
    endtask

    task automatic test_field_extremes();
        image_spec_t s;
        s = sound_spec(1);
        s.date_word = 32'hffff_ffff;
        s.time_word = 32'hffff_ffff;
        send_spec(s);
        s = sound_spec(0);
        s.date_word = 32'h0;
        s.time_word = 32'h0;
        send_spec(s);
        s = sound_spec(2);
        s.size_word = 32'hffff_ffff;
        send_spec(s);
        wait_for_verdicts();
    endtask

    task automatic send_random_image();
        image_spec_t s;
        int          pick;
        int          size;
        int          total;
        pick = $urandom_range(0, 99);
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        s = sound_spec(size);
        total = (s.with_prefix ? 4 : 0) + 24 + s.body_bytes;
        if (pick < 50)
            send_spec(s);
        else if (pick < 54)
        begin
            s.magic = $urandom;
            send_spec(s);
        end
        else if (pick < 58)
        begin
            s.hdr_sum_flip = 8'($urandom_range(1, 255));
            send_spec(s);
        end
        else if (pick < 62)
        begin
            s.reserved = 16'($urandom_range(1, 65535));
            send_spec(s);
        end
        else if (pick < 66)
        begin
            s.type_word[15:0] = 16'($urandom);
            send_spec(s);
        end
        else if (pick < 70)
        begin
            s.type_word[31:16] = 16'($urandom);
            send_spec(s);
        end
        else if (pick < 78)
        begin
            s.cut_len = $urandom_range(1, total - 1);
            send_spec(s);
        end
        else if (pick < 84)
        begin
            s.body_sum_flip = 8'($urandom_range(1, 255));
            send_spec(s);
        end
        else if (pick < 90)
        begin
            s.body_bytes = size + $urandom_range(1, 6);
            send_spec(s);
        end
        else if (pick < 95)
            send_noise($urandom_range(1, 40));
        else
        begin
            s.flip_at = $urandom_range(0, total - 1);
            s.flip_mask = 8'($urandom_range(1, 255));
            send_spec(s);
        end
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          images;
        int unsigned budget;
        int unsigned stop_at;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 0;
                    budget = 120;
                end
                1:
                begin
                    sender_idle_pct = 58;
                    receiver_stall_pct <= 0;
                    budget = 120;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 58;
                    budget = 120;
                end
                3:
                begin
                    sender_idle_pct = 21;
                    receiver_stall_pct <= 21;
                    budget = 120;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 0;
                    budget = 120;
                end
            endcase
            stop_at = bytes_sent + budget;
            images = 0;
            while (bytes_sent < stop_at || images < 4)
            begin
                send_random_image();
                images++;
            end
        end
        wait_for_verdicts();
        sender_idle_pct = 0;
    endtask

    // receiver holds off while short images keep coming, so input must stall
    task automatic test_output_backpressure();
        image_spec_t s;
        int          i;
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
        hold_armed <= 1'b1;
        for (i = 0; i < 30; i++)
            send_noise($urandom_range(1, 3));
        s = sound_spec(4);
        send_spec(s);
        wait_for_verdicts();
    endtask

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        clear_image_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_clean_images();
        test_header_faults();
        test_short_images();
        test_body_faults();
        test_field_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_for_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/fihc_pkg.sv
rtl/core/firmware_image_header_checker_top.sv
rtl/core/fihc_checker.sv
tb/tb_firmware_image_header_checker_top.sv
